/* rtl/omr_pkg.sv */
// ----------------------------------------------------------------------------
// omr_pkg
// shared codes, defaults and memory control word for the message ring
// ----------------------------------------------------------------------------
package omr_pkg;

   localparam int ENTRIES_DEF     = 16;
   localparam int ENTRY_BYTES_DEF = 32;

   localparam int OP_W     = 2;
   localparam int BYTE_W   = 8;
   localparam int LIMIT_W  = 6;

   typedef enum logic [OP_W-1:0] {
      OP_PUT      = 2'd0,
      OP_PEEK     = 2'd1,
      OP_ADV_PEEK = 2'd2,
      OP_DROP     = 2'd3
   } op_type;

   typedef struct packed {
      logic byte_we;
      logic byte_re;
      logic len_we;
      logic len_re;
   } mem_ctrl_type;

endpackage

/* rtl/omr_store.sv */
// ----------------------------------------------------------------------------
// omr_store
// message byte memory and slot length memory, registered read outputs
// ----------------------------------------------------------------------------
module omr_store #(
   parameter int ENTRIES     = omr_pkg::ENTRIES_DEF,
   parameter int ENTRY_BYTES = omr_pkg::ENTRY_BYTES_DEF,
   localparam int IDX_W  = $clog2(ENTRIES),
   localparam int LEN_W  = $clog2(ENTRY_BYTES + 1),
   localparam int ADDR_W = $clog2(ENTRIES * ENTRY_BYTES)
) (
   input  logic                      clock,
   input  omr_pkg::mem_ctrl_type     ctrl,
   input  logic [ADDR_W-1:0]         byte_addr,
   input  logic [omr_pkg::BYTE_W-1:0] byte_wdata,
   output logic [omr_pkg::BYTE_W-1:0] byte_rdata,
   input  logic [IDX_W-1:0]          len_addr,
   input  logic [LEN_W-1:0]          len_wdata,
   output logic [LEN_W-1:0]          len_rdata
);

   logic [omr_pkg::BYTE_W-1:0] byte_mem [ENTRIES*ENTRY_BYTES];
   logic [LEN_W-1:0]           len_mem  [ENTRIES];
   logic [omr_pkg::BYTE_W-1:0] byte_rdata_ff;
   logic [LEN_W-1:0]           len_rdata_ff;

   always_ff @(posedge clock) begin
      if (ctrl.byte_we) begin
         byte_mem[byte_addr] <= byte_wdata;
      end
      if (ctrl.byte_re) begin
         byte_rdata_ff <= byte_mem[byte_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.len_we) begin
         len_mem[len_addr] <= len_wdata;
      end
      if (ctrl.len_re) begin
         len_rdata_ff <= len_mem[len_addr];
      end
   end

   assign byte_rdata = byte_rdata_ff;
   assign len_rdata  = len_rdata_ff;

endmodule

/* rtl/overwriting_message_ring.sv */
// ----------------------------------------------------------------------------
// overwriting_message_ring
// ring of short messages, oldest overwritten when full, peeked byte by byte
// ----------------------------------------------------------------------------
//  channel | ports                                        | dir
//  req     | req_valid req_stall req_op req_data_byte     | in
//          | req_end_of_message req_read_limit            |
//  rsp     | rsp_valid rsp_stall rsp_found rsp_out_length | out
//          | rsp_out_byte rsp_last_result                 |
//
//  put and discard words are taken in the idle state without stalling.
//  a peek reads the head length in ST_LEN, then each returned word goes
//  through ST_BYTE for the byte memory read and ST_SEND to present the word.
//  an empty answer goes straight to ST_SEND, a zero length answer via ST_LEN.
//  rsp_stall holds the presented word; req_stall is high until a read finishes.
//  synchronous reset clears the state, the ring indices and the fill count only.
// ----------------------------------------------------------------------------
module overwriting_message_ring #(
   parameter int ENTRIES     = omr_pkg::ENTRIES_DEF,
   parameter int ENTRY_BYTES = omr_pkg::ENTRY_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [omr_pkg::OP_W-1:0]    req_op,
   input  logic [omr_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic                        req_end_of_message,
   input  logic [omr_pkg::LIMIT_W-1:0] req_read_limit,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_found,
   output logic [omr_pkg::LIMIT_W-1:0] rsp_out_length,
   output logic [omr_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_last_result
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int LEN_W  = $clog2(ENTRY_BYTES + 1);
   localparam int ADDR_W = $clog2(ENTRIES * ENTRY_BYTES);
   localparam int LIM_W  = omr_pkg::LIMIT_W;
   localparam int CMP_W  = (LEN_W > LIM_W) ? LEN_W : LIM_W;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(ENTRIES - 1);
   localparam logic [LEN_W-1:0] FULL_LEN  = LEN_W'(ENTRY_BYTES);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LEN  = 4'b0010,
      ST_BYTE = 4'b0100,
      ST_SEND = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   logic [IDX_W-1:0]           rd_ff, rd_in;
   logic [IDX_W-1:0]           wr_ff, wr_in;
   logic [LEN_W-1:0]           pc_ff, pc_in;
   logic [LIM_W-1:0]           limit_ff, limit_in;
   logic [LIM_W-1:0]           n_ff, n_in;
   logic [LIM_W-1:0]           k_ff, k_in;
   logic                       found_ff, found_in;
   logic [LIM_W-1:0]           length_ff, length_in;
   logic [omr_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                       last_ff, last_in;

   omr_pkg::mem_ctrl_type      ctrl;
   logic [ADDR_W-1:0]          byte_addr;
   logic [omr_pkg::BYTE_W-1:0] byte_rdata;
   logic [IDX_W-1:0]           len_addr;
   logic [LEN_W-1:0]           len_wdata;
   logic [LEN_W-1:0]           len_rdata;

   logic [IDX_W-1:0]           head;
   logic [IDX_W-1:0]           rd_next;
   logic [IDX_W-1:0]           wr_next;
   logic                       pc_room;
   logic [CMP_W-1:0]           len_ext;
   logic [CMP_W-1:0]           lim_ext;
   logic [CMP_W-1:0]           n_full;
   logic [LIM_W-1:0]           n_len;

   function automatic logic [IDX_W-1:0] slot_next(logic [IDX_W-1:0] s);
      return (s == LAST_SLOT) ? '0 : s + IDX_W'(1);
   endfunction

   function automatic logic [ADDR_W-1:0] slot_base(logic [IDX_W-1:0] s);
      return ADDR_W'(s) * ADDR_W'(ENTRY_BYTES);
   endfunction

   assign rd_next = slot_next(rd_ff);
   assign wr_next = slot_next(wr_ff);
   assign pc_room = (pc_ff < FULL_LEN);
   assign head    = ((omr_pkg::op_type'(req_op) == omr_pkg::OP_ADV_PEEK) && (rd_ff != wr_ff))
                    ? rd_next : rd_ff;
   assign len_ext = CMP_W'(len_rdata);
   assign lim_ext = CMP_W'(limit_ff);
   assign n_full  = (len_ext < lim_ext) ? len_ext : lim_ext;
   assign n_len   = n_full[LIM_W-1:0];

   always_comb begin
      state_in  = state_ff;
      rd_in     = rd_ff;
      wr_in     = wr_ff;
      pc_in     = pc_ff;
      limit_in  = limit_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      found_in  = found_ff;
      length_in = length_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      ctrl      = '0;
      byte_addr = slot_base(rd_ff);
      len_addr  = rd_ff;
      len_wdata = pc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (omr_pkg::op_type'(req_op))
                  omr_pkg::OP_PUT: begin
                     if (pc_room) begin
                        ctrl.byte_we = 1'b1;
                        byte_addr    = slot_base(wr_ff) + ADDR_W'(pc_ff);
                        pc_in        = pc_ff + LEN_W'(1);
                     end
                     if (req_end_of_message) begin
                        ctrl.len_we = 1'b1;
                        len_addr    = wr_ff;
                        len_wdata   = pc_room ? pc_ff + LEN_W'(1) : pc_ff;
                        wr_in       = wr_next;
                        pc_in       = '0;
                        if (wr_next == rd_ff) begin
                           rd_in = rd_next;
                        end
                     end
                  end
                  omr_pkg::OP_PEEK, omr_pkg::OP_ADV_PEEK: begin
                     rd_in    = head;
                     limit_in = req_read_limit;
                     if (head == wr_ff) begin
                        found_in  = 1'b0;
                        length_in = '0;
                        byte_in   = '0;
                        last_in   = 1'b1;
                        state_in  = ST_SEND;
                     end else begin
                        ctrl.len_re = 1'b1;
                        len_addr    = head;
                        state_in    = ST_LEN;
                     end
                  end
                  omr_pkg::OP_DROP: begin
                     if (rd_ff != wr_ff) begin
                        rd_in = rd_next;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LEN: begin
            if (n_len == '0) begin
               found_in  = 1'b1;
               length_in = '0;
               byte_in   = '0;
               last_in   = 1'b1;
               state_in  = ST_SEND;
            end else begin
               n_in         = n_len;
               k_in         = '0;
               ctrl.byte_re = 1'b1;
               byte_addr    = slot_base(rd_ff);
               state_in     = ST_BYTE;
            end
         end
         ST_BYTE: begin
            found_in  = 1'b1;
            length_in = n_ff;
            byte_in   = byte_rdata;
            last_in   = ((k_ff + LIM_W'(1)) == n_ff);
            state_in  = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in         = k_ff + LIM_W'(1);
                  ctrl.byte_re = 1'b1;
                  byte_addr    = slot_base(rd_ff) + ADDR_W'(k_ff + LIM_W'(1));
                  state_in     = ST_BYTE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rd_ff    <= '0;
         wr_ff    <= '0;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         pc_ff    <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff  <= limit_in;
      n_ff      <= n_in;
      k_ff      <= k_in;
      found_ff  <= found_in;
      length_ff <= length_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
   end

   omr_store #(
      .ENTRIES     (ENTRIES),
      .ENTRY_BYTES (ENTRY_BYTES)
   ) u_store (
      .clock      (clock),
      .ctrl       (ctrl),
      .byte_addr  (byte_addr),
      .byte_wdata (req_data_byte),
      .byte_rdata (byte_rdata),
      .len_addr   (len_addr),
      .len_wdata  (len_wdata),
      .len_rdata  (len_rdata)
   );

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_SEND);
   assign rsp_found       = found_ff;
   assign rsp_out_length  = length_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_result = last_ff;

`ifndef SYNTHESIS
   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_last_result && (rsp_out_length == '0)))
      else $error("empty answer not a single zero length word");

   a_more_words: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_result) |-> (rsp_found && (rsp_out_length != '0)))
      else $error("continuation word without a message");

   a_fill_count: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= FULL_LEN)
      else $error("fill count beyond slot size");

   a_head_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BYTE) |=> $stable(rd_ff) && $stable(wr_ff))
      else $error("ring indices moved during a read");
`endif

endmodule

/* test/message_ring_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_ring_checker
// watches both channels of the message ring, keeps its own copy of the ring
// and compares every returned word with the oldest predicted one
// ----------------------------------------------------------------------------
module message_ring_checker #(
   parameter int ENTRIES     = omr_pkg::ENTRIES_DEF,
   parameter int ENTRY_BYTES = omr_pkg::ENTRY_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [omr_pkg::OP_W-1:0]    req_op,
   input  logic [omr_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic                        req_end_of_message,
   input  logic [omr_pkg::LIMIT_W-1:0] req_read_limit,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic                        rsp_found,
   input  logic [omr_pkg::LIMIT_W-1:0] rsp_out_length,
   input  logic [omr_pkg::BYTE_W-1:0]  rsp_out_byte,
   input  logic                        rsp_last_result,
   output int                          fail_count,
   output int                          pending_words,
   output int                          checked_words,
   output int                          overwrite_count
);

   typedef struct packed {
      logic                        found;
      logic [omr_pkg::LIMIT_W-1:0] length;
      logic [omr_pkg::BYTE_W-1:0]  data;
      logic                        last;
   } reply_type;

   logic [omr_pkg::BYTE_W-1:0]  msg_store [ENTRIES][ENTRY_BYTES];
   logic [omr_pkg::LIMIT_W-1:0] msg_len [ENTRIES];
   int                          head_slot;
   int                          tail_slot;
   int                          fill_bytes;
   int                          errors;
   int                          checked;
   int                          overwrites;
   reply_type                   expected_replies [$];

   initial begin
      fail_count      = 0;
      pending_words   = 0;
      checked_words   = 0;
      overwrite_count = 0;
      errors          = 0;
      checked         = 0;
      overwrites      = 0;
   end

   function automatic int ring_next(input int slot);
      return (slot + 1 >= ENTRIES) ? 0 : slot + 1;
   endfunction

   task automatic queue_head_read(input logic [omr_pkg::LIMIT_W-1:0] limit);
      int        len;
      int        n;
      reply_type r;
      if (head_slot == tail_slot) begin
         r = '{found: 1'b0, length: '0, data: '0, last: 1'b1};
         expected_replies.push_back(r);
         return;
      end
      len = msg_len[head_slot];
      n   = (int'(limit) < len) ? int'(limit) : len;
      if (n == 0) begin
         r = '{found: 1'b1, length: '0, data: '0, last: 1'b1};
         expected_replies.push_back(r);
         return;
      end
      for (int k = 0; k < n; k++) begin
         r.found  = 1'b1;
         r.length = omr_pkg::LIMIT_W'(n);
         r.data   = msg_store[head_slot][k];
         r.last   = (k == n - 1);
         expected_replies.push_back(r);
      end
   endtask

   task automatic ring_update(input omr_pkg::op_type op,
                              input logic [omr_pkg::BYTE_W-1:0] b,
                              input logic eom,
                              input logic [omr_pkg::LIMIT_W-1:0] limit);
      int        nxt;
      reply_type r;
      case (op)
         omr_pkg::OP_PUT: begin
            if (fill_bytes < ENTRY_BYTES) begin
               msg_store[tail_slot][fill_bytes] = b;
               fill_bytes++;
            end
            if (eom) begin
               nxt = ring_next(tail_slot);
               if (nxt == head_slot) begin
                  head_slot = ring_next(head_slot);
                  overwrites++;
               end
               msg_len[tail_slot] = omr_pkg::LIMIT_W'(fill_bytes);
               tail_slot  = nxt;
               fill_bytes = 0;
            end
         end
         omr_pkg::OP_PEEK: begin
            queue_head_read(limit);
         end
         omr_pkg::OP_ADV_PEEK: begin
            if (head_slot == tail_slot) begin
               r = '{found: 1'b0, length: '0, data: '0, last: 1'b1};
               expected_replies.push_back(r);
            end else begin
               head_slot = ring_next(head_slot);
               queue_head_read(limit);
            end
         end
         default: begin
            if (head_slot != tail_slot)
               head_slot = ring_next(head_slot);
         end
      endcase
   endtask

   task automatic compare_reply();
      reply_type want;
      if (expected_replies.size() == 0) begin
         $error("unexpected word: found %0d out_length %0d out_byte %0h last_result %0d",
                rsp_found, rsp_out_length, rsp_out_byte, rsp_last_result);
         errors++;
         return;
      end
      want = expected_replies.pop_front();
      checked++;
      if (rsp_found !== want.found) begin
         $error("found: expected %0d, actual %0d", want.found, rsp_found);
         errors++;
      end
      if (rsp_out_length !== want.length) begin
         $error("out_length: expected %0d, actual %0d", want.length, rsp_out_length);
         errors++;
      end
      if (rsp_out_byte !== want.data) begin
         $error("out_byte: expected %0h, actual %0h", want.data, rsp_out_byte);
         errors++;
      end
      if (rsp_last_result !== want.last) begin
         $error("last_result: expected %0d, actual %0d", want.last, rsp_last_result);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         head_slot  = 0;
         tail_slot  = 0;
         fill_bytes = 0;
         expected_replies.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            compare_reply();
         if (req_valid && !req_stall)
            ring_update(omr_pkg::op_type'(req_op), req_data_byte, req_end_of_message,
                        req_read_limit);
      end
      fail_count      <= errors;
      pending_words   <= expected_replies.size();
      checked_words   <= checked;
      overwrite_count <= overwrites;
   end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives put, peek, advance and discard words into the message ring under
// changing idle patterns on both sides; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT = 1000000;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [omr_pkg::OP_W-1:0]    req_op;
   logic [omr_pkg::BYTE_W-1:0]  req_data_byte;
   logic                        req_end_of_message;
   logic [omr_pkg::LIMIT_W-1:0] req_read_limit;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_found;
   logic [omr_pkg::LIMIT_W-1:0] rsp_out_length;
   logic [omr_pkg::BYTE_W-1:0]  rsp_out_byte;
   logic                        rsp_last_result;

   int fail_count;
   int pending_words;
   int checked_words;
   int overwrite_count;
   int words_sent = 0;
   int send_idle_pct = 13;
   int recv_idle_pct = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   overwriting_message_ring i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .req_read_limit     (req_read_limit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_out_length     (rsp_out_length),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_result    (rsp_last_result)
   );

   message_ring_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .req_read_limit     (req_read_limit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_out_length     (rsp_out_length),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last_result    (rsp_last_result),
      .fail_count         (fail_count),
      .pending_words      (pending_words),
      .checked_words      (checked_words),
      .overwrite_count    (overwrite_count)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [omr_pkg::LIMIT_W-1:0] pick_limit();
      if ($urandom_range(99) < 15)
         return omr_pkg::LIMIT_W'($urandom_range(63));
      return omr_pkg::LIMIT_W'($urandom_range(33));
   endfunction

   task automatic send_word(input omr_pkg::op_type op,
                            input logic [omr_pkg::BYTE_W-1:0] b,
                            input logic eom,
                            input logic [omr_pkg::LIMIT_W-1:0] limit);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_op             <= op;
      req_data_byte      <= b;
      req_end_of_message <= eom;
      req_read_limit     <= limit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_read(input omr_pkg::op_type op);
      send_word(op, omr_pkg::BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                pick_limit());
   endtask

   // message bytes, with reads and discards slipped in between at a given rate
   task automatic put_message(input int len, input int mix_pct);
      for (int k = 0; k < len; k++) begin
         if (k > 0 && $urandom_range(99) < mix_pct)
            send_read(omr_pkg::op_type'($urandom_range(1, 3)));
         send_word(omr_pkg::OP_PUT, omr_pkg::BYTE_W'($urandom_range(255)), k == len - 1,
                   pick_limit());
      end
   endtask

   task automatic drain_ring();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   task automatic random_phase(input int words);
      int stop;
      int pick;
      int len;
      stop = words_sent + words;
      while (words_sent < stop) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            len = $urandom_range(99);
            if (len < 70)
               len = $urandom_range(1, 6);
            else if (len < 90)
               len = $urandom_range(7, 32);
            else
               len = $urandom_range(33, 40);
            put_message(len, 15);
         end else if (pick < 48) begin
            // enough short messages to fill the ring and, mostly, to wrap it
            repeat ($urandom_range(15, 18))
               put_message($urandom_range(1, 3), 0);
         end else if (pick < 63) begin
            send_read(omr_pkg::OP_PEEK);
         end else if (pick < 73) begin
            send_read(omr_pkg::OP_ADV_PEEK);
         end else if (pick < 83) begin
            send_read(omr_pkg::OP_DROP);
         end else if (pick < 85) begin
            drain_ring();
         end else begin
            send_word(omr_pkg::op_type'($urandom_range(3)),
                      omr_pkg::BYTE_W'($urandom_range(255)),
                      1'($urandom_range(1)), omr_pkg::LIMIT_W'($urandom_range(63)));
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_op             = omr_pkg::OP_PUT;
      req_data_byte      = '0;
      req_end_of_message = 1'b0;
      req_read_limit     = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 13;
      recv_idle_pct = 73;

      // empty ring
      send_word(omr_pkg::OP_PEEK, 8'h00, 1'b0, 6'd5);
      send_word(omr_pkg::OP_ADV_PEEK, 8'hFF, 1'b1, 6'd32);
      send_word(omr_pkg::OP_DROP, 8'h00, 1'b0, 6'd0);
      // two byte message, extreme bytes, then limits zero, one and above length
      send_word(omr_pkg::OP_PUT, 8'h00, 1'b0, 6'd63);
      send_word(omr_pkg::OP_PUT, 8'hFF, 1'b1, 6'd0);
      send_word(omr_pkg::OP_PEEK, 8'h00, 1'b0, 6'd0);
      send_word(omr_pkg::OP_PEEK, 8'h00, 1'b0, 6'd1);
      send_word(omr_pkg::OP_PEEK, 8'h00, 1'b0, 6'd63);
      send_word(omr_pkg::OP_PUT, 8'hA5, 1'b1, 6'd0);
      send_word(omr_pkg::OP_PUT, 8'h5A, 1'b1, 6'd0);
      send_word(omr_pkg::OP_ADV_PEEK, 8'h00, 1'b0, 6'd32);
      send_word(omr_pkg::OP_DROP, 8'h00, 1'b0, 6'd0);
      send_word(omr_pkg::OP_PEEK, 8'h00, 1'b0, 6'd32);
      // pending message survives reads and discards
      send_word(omr_pkg::OP_PUT, 8'h3C, 1'b0, 6'd0);
      send_word(omr_pkg::OP_PEEK, 8'h00, 1'b0, 6'd33);
      send_word(omr_pkg::OP_DROP, 8'h00, 1'b0, 6'd0);
      send_word(omr_pkg::OP_PEEK, 8'h00, 1'b0, 6'd4);
      send_word(omr_pkg::OP_PUT, 8'hC3, 1'b1, 6'd0);
      send_word(omr_pkg::OP_PEEK, 8'h00, 1'b0, 6'd2);
      // discard-then-peek that empties the ring
      send_word(omr_pkg::OP_ADV_PEEK, 8'h00, 1'b0, 6'd7);
      drain_ring();

      random_phase(130);
      drain_ring();

      send_idle_pct = 73;
      recv_idle_pct = 13;
      random_phase(125);
      drain_ring();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(125);

      drain_ring();
      repeat (20) @(posedge clock);

      $display("%0d words sent, %0d result words checked, %0d messages overwritten",
               words_sent, checked_words, overwrite_count);
      $display("idling: sender 13%% receiver 73%%, then 73%%/13%%, then none");
      if (fail_count == 0 && pending_words == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
